// ===== rtl/ats_pkg.sv =====
`default_nettype none

package ats_pkg;

    // Field widths
    localparam int WEIGHT_W   = 25;
    localparam int RCOL_W     = 32;
    localparam int RCOIN_W    = 24;
    localparam int PROB_W     = 25;
    localparam int IDX_OUT_W  = 10;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 16;

    // 1.0 in Q1.24
    localparam logic [PROB_W-1:0] ONE_Q24 = 25'h100_0000;

    // Input selector (tuser)
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Result kind (tuser)
    localparam logic KIND_BUILD  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0_0000_0000_0001,
        ST_SC_RD   = 13'b0_0000_0000_0010,
        ST_SC_MUL  = 13'b0_0000_0000_0100,
        ST_SC_WR   = 13'b0_0000_0000_1000,
        ST_PR_POP  = 13'b0_0000_0001_0000,
        ST_PR_RD   = 13'b0_0000_0010_0000,
        ST_PR_CALC = 13'b0_0000_0100_0000,
        ST_DR_POP  = 13'b0_0000_1000_0000,
        ST_DR_WR   = 13'b0_0001_0000_0000,
        ST_SM_MUL  = 13'b0_0010_0000_0000,
        ST_SM_RD   = 13'b0_0100_0000_0000,
        ST_SM_CMP  = 13'b0_1000_0000_0000,
        ST_EMIT    = 13'b1_0000_0000_0000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/alias_table_sampler.sv =====
`default_nettype none

// Channel  Dir  Fields (tdata from bit 0 up)                     tuser  tlast
// s_axis   in   weight[24:0] rand_column[56:25] rand_coin[80:57]  op     last
// m_axis   out  sample_index[9:0] error[10] overflow[11]          kind   -
//
// A load word is taken in idle; a sample goes through multiply, read and compare states,
// then waits for the output hand-off. A load marked last starts the build: each entry is
// scaled (read, multiply, write), entries are paired (pop, read, calc) while both stacks
// hold one, each leftover entry is popped and written, then the result is emitted; the
// pace is set by the shared multiplier/adder and the single write port of the weight store.
// Reset (i_rst_n low, synchronous) drops any table; the stores need no clearing.
// s_axis_tready is high only in idle; a result waiting on m_axis holds only the next result.
module alias_table_sampler import ats_pkg::*; #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // weight, rand_column, rand_coin
    input  wire logic [0:0]           s_axis_tuser,  // op
    input  wire logic                 s_axis_tlast,  // last
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // sample_index, error, overflow
    output logic      [0:0]           m_axis_tuser   // kind
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = WEIGHT_W + CW;   // scaled weight, never grows past w*n
    localparam int PW = RCOL_W + CW;

    // ---------------------------------------------------------------- input word
    logic [WEIGHT_W-1:0] in_weight;
    logic [RCOL_W-1:0]   in_rcol;
    logic [RCOIN_W-1:0]  in_rcoin;
    logic                in_op;

    assign in_weight = s_axis_tdata[WEIGHT_W-1:0];
    assign in_rcol   = s_axis_tdata[WEIGHT_W +: RCOL_W];
    assign in_rcoin  = s_axis_tdata[WEIGHT_W+RCOL_W +: RCOIN_W];
    assign in_op     = s_axis_tuser[0];

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;

    logic [CW-1:0]      r_count;      // entries in table
    logic               r_ready;      // table built
    logic               r_dropped;    // load beyond capacity seen
    logic [CW-1:0]      r_idx;        // scale pass index
    logic [PW-1:0]      r_prod;
    logic [RCOL_W-1:0]  r_rand_col;
    logic [RCOIN_W-1:0] r_rand_coin;
    logic [IW-1:0]      r_less, r_more, r_col;
    logic               r_from_large;

    logic                 r_res_kind, r_res_err, r_res_ovf;
    logic [IDX_OUT_W-1:0] r_res_idx;
    logic                 r_out_valid, r_out_kind, r_out_err, r_out_ovf;
    logic [IDX_OUT_W-1:0] r_out_idx;

    // ---------------------------------------------------------------- stores
    logic [SW-1:0]     r_wmem [MAX_ENTRIES];
    logic [SW-1:0]     r_wrd_a, r_wrd_b;
    logic [PROB_W-1:0] r_prob [MAX_ENTRIES];
    logic [PROB_W-1:0] r_prob_rd;
    logic [IW-1:0]     r_alias [MAX_ENTRIES];
    logic [IW-1:0]     r_alias_rd;

    // ---------------------------------------------------------------- control nets
    logic acc, ld, sm, room, out_free;
    logic [CW-1:0] cnt_eff, n_count;
    logic          n_dropped;

    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr_a;
    logic [SW-1:0] w_wdata;

    logic              pt_we;
    logic [IW-1:0]     pt_addr, pt_raddr, dr_k;
    logic [PROB_W-1:0] pt_prob;
    logic [IW-1:0]     pt_alias;

    logic          stk_clr, sm_push, lg_push, sm_pop, lg_pop, sm_empty, lg_empty;
    logic [IW-1:0] stk_wdata, sm_rd, lg_rd;

    logic [RCOL_W-1:0] mul_a;
    logic [PW-1:0]     alu_prod;
    logic [SW-1:0]     alu_res;
    logic              alu_gt;

    logic [IW-1:0]        pick;
    logic [IW+IDX_OUT_W-1:0] pick_ext;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc      = s_axis_tvalid & s_axis_tready;
    assign ld       = acc & (in_op == OP_LOAD);
    assign sm       = acc & (in_op == OP_SAMPLE);
    assign out_free = ~r_out_valid | m_axis_tready;

    // a load after a finished build starts a fresh table
    assign cnt_eff   = r_ready ? '0 : r_count;
    assign room      = (cnt_eff < CW'(MAX_ENTRIES));
    assign n_count   = room ? cnt_eff + CW'(1) : cnt_eff;
    assign n_dropped = (~r_ready & r_dropped) | ~room;

    // ---------------------------------------------------------------- shared unit
    assign mul_a = (r_state == ST_SM_MUL) ? r_rand_col : RCOL_W'(r_wrd_a[WEIGHT_W-1:0]);

    ats_alu #(.CW(CW), .SW(SW)) u_alu (
        .i_mul_a  (mul_a),
        .i_mul_b  (r_count),
        .o_prod   (alu_prod),
        .i_pair   (r_state == ST_PR_CALC),
        .i_wm     (r_wrd_b),
        .i_wl     (r_wrd_a),
        .i_pass   (r_prod[SW-1:0]),
        .o_res    (alu_res),
        .o_gt_one (alu_gt)
    );

    // ---------------------------------------------------------------- work stacks
    assign stk_clr   = ld & s_axis_tlast;
    assign stk_wdata = (r_state == ST_SC_WR) ? r_idx[IW-1:0] : r_more;
    assign sm_push   = ((r_state == ST_SC_WR) | (r_state == ST_PR_CALC)) & ~alu_gt;
    assign lg_push   = ((r_state == ST_SC_WR) | (r_state == ST_PR_CALC)) & alu_gt;
    assign sm_pop    = ((r_state == ST_PR_POP) & ~sm_empty & ~lg_empty) |
                       ((r_state == ST_DR_POP) & ~sm_empty);
    assign lg_pop    = ((r_state == ST_PR_POP) & ~sm_empty & ~lg_empty) |
                       ((r_state == ST_DR_POP) & sm_empty & ~lg_empty);

    ats_stack #(.DEPTH(MAX_ENTRIES), .IW(IW), .CW(CW)) u_small (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (stk_clr),
        .i_push  (sm_push),
        .i_pop   (sm_pop),
        .i_wdata (stk_wdata),
        .o_rdata (sm_rd),
        .o_empty (sm_empty)
    );

    ats_stack #(.DEPTH(MAX_ENTRIES), .IW(IW), .CW(CW)) u_large (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (stk_clr),
        .i_push  (lg_push),
        .i_pop   (lg_pop),
        .i_wdata (stk_wdata),
        .o_rdata (lg_rd),
        .o_empty (lg_empty)
    );

    // ---------------------------------------------------------------- store ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = cnt_eff[IW-1:0];
        w_wdata = SW'(in_weight);
        if (ld & room) begin
            w_we = 1'b1;
        end else if (r_state == ST_SC_WR) begin
            w_we    = 1'b1;
            w_waddr = r_idx[IW-1:0];
            w_wdata = r_prod[SW-1:0];
        end else if (r_state == ST_PR_CALC) begin
            w_we    = 1'b1;
            w_waddr = r_more;
            w_wdata = alu_res;
        end
    end

    assign w_raddr_a = (r_state == ST_SC_RD) ? r_idx[IW-1:0] : sm_rd;

    assign dr_k     = r_from_large ? lg_rd : sm_rd;
    assign pt_we    = (r_state == ST_PR_CALC) | (r_state == ST_DR_WR);
    assign pt_addr  = (r_state == ST_PR_CALC) ? r_less : dr_k;
    assign pt_prob  = (r_state == ST_PR_CALC) ? r_wrd_a[PROB_W-1:0] : ONE_Q24;
    assign pt_alias = (r_state == ST_PR_CALC) ? r_more : dr_k;
    assign pt_raddr = r_prod[RCOL_W +: IW];   // column = floor(n * rand_column)

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        r_wrd_a <= r_wmem[w_raddr_a];
        r_wrd_b <= r_wmem[lg_rd];
        if (pt_we) begin
            r_prob[pt_addr]  <= pt_prob;
            r_alias[pt_addr] <= pt_alias;
        end
        r_prob_rd  <= r_prob[pt_raddr];
        r_alias_rd <= r_alias[pt_raddr];
    end

    // biased coin: keep the column or take its alias
    assign pick     = ({1'b0, r_rand_coin} < r_prob_rd) ? r_col : r_alias_rd;
    assign pick_ext = (IW+IDX_OUT_W)'(pick);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (ld & s_axis_tlast) begin
                    n_state = (n_count == '0) ? ST_EMIT : ST_SC_RD;
                end else if (sm) begin
                    n_state = r_ready ? ST_SM_MUL : ST_EMIT;
                end
            end
            ST_SC_RD:   n_state = ST_SC_MUL;
            ST_SC_MUL:  n_state = ST_SC_WR;
            ST_SC_WR: begin
                n_state = (r_idx + CW'(1) == r_count) ? ST_PR_POP : ST_SC_RD;
            end
            ST_PR_POP: begin
                n_state = (~sm_empty & ~lg_empty) ? ST_PR_RD : ST_DR_POP;
            end
            ST_PR_RD:   n_state = ST_PR_CALC;
            ST_PR_CALC: n_state = ST_PR_POP;
            ST_DR_POP: begin
                n_state = (~sm_empty | ~lg_empty) ? ST_DR_WR : ST_EMIT;
            end
            ST_DR_WR:   n_state = ST_DR_POP;
            ST_SM_MUL:  n_state = ST_SM_RD;
            ST_SM_RD:   n_state = ST_SM_CMP;
            ST_SM_CMP:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld) begin
                r_count   <= n_count;
                r_ready   <= 1'b0;
                r_dropped <= s_axis_tlast ? 1'b0 : n_dropped;
            end
            if ((r_state == ST_DR_POP) & sm_empty & lg_empty) begin
                r_ready <= 1'b1;
            end
            if ((r_state == ST_EMIT) & out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_idx      <= '0;
            r_res_kind <= KIND_BUILD;
            r_res_idx  <= '0;
            r_res_err  <= (n_count == '0);
            r_res_ovf  <= n_dropped;
        end
        if (sm) begin
            r_rand_col  <= in_rcol;
            r_rand_coin <= in_rcoin;
            r_res_kind  <= KIND_SAMPLE;
            r_res_idx   <= '0;
            r_res_err   <= ~r_ready;
            r_res_ovf   <= 1'b0;
        end
        if ((r_state == ST_SC_MUL) | (r_state == ST_SM_MUL)) begin
            r_prod <= alu_prod;
        end
        if (r_state == ST_SC_WR) begin
            r_idx <= r_idx + CW'(1);
        end
        if (r_state == ST_PR_RD) begin
            r_less <= sm_rd;
            r_more <= lg_rd;
        end
        if (r_state == ST_DR_POP) begin
            r_from_large <= sm_empty;
        end
        if (r_state == ST_SM_RD) begin
            r_col <= pt_raddr;
        end
        if (r_state == ST_SM_CMP) begin
            r_res_idx <= pick_ext[IDX_OUT_W-1:0];
            r_res_err <= 1'b0;
        end
        if ((r_state == ST_EMIT) & out_free) begin
            r_out_kind <= r_res_kind;
            r_out_idx  <= r_res_idx;
            r_out_err  <= r_res_err;
            r_out_ovf  <= r_res_ovf;
        end
    end

    // ---------------------------------------------------------------- output word
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = M_TDATA_W'({r_out_ovf, r_out_err, r_out_idx});
    assign m_axis_tuser[0] = r_out_kind;

endmodule

`default_nettype wire

// ===== rtl/ats_stack.sv =====
`default_nettype none

// Index stack: one push or one pop a cycle, registered read of the top.
module ats_stack #(
    parameter int DEPTH = 1024,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clr,
    input  wire logic          i_push,
    input  wire logic          i_pop,
    input  wire logic [IW-1:0] i_wdata,
    output logic      [IW-1:0] o_rdata,
    output logic               o_empty
);

    logic [IW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_ptr;
    logic [IW-1:0] r_rdata;
    logic [CW-1:0] top;

    assign top     = r_ptr - CW'(1);
    assign o_empty = (r_ptr == '0);
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_clr) begin
            r_ptr <= '0;
        end else if (i_push) begin
            r_ptr <= r_ptr + CW'(1);
        end else if (i_pop) begin
            r_ptr <= top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_ptr[IW-1:0]] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= r_mem[top[IW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ats_alu.sv =====
`default_nettype none

// Shared arithmetic: one multiplier, one pairing add/subtract, one compare to 1.0.
module ats_alu import ats_pkg::*; #(
    parameter int CW = 11,
    parameter int SW = 36
) (
    input  wire logic [RCOL_W-1:0]    i_mul_a,
    input  wire logic [CW-1:0]        i_mul_b,
    output logic      [RCOL_W+CW-1:0] o_prod,
    input  wire logic                 i_pair,
    input  wire logic [SW-1:0]        i_wm,
    input  wire logic [SW-1:0]        i_wl,
    input  wire logic [SW-1:0]        i_pass,
    output logic      [SW-1:0]        o_res,
    output logic                      o_gt_one
);

    logic [SW:0] sum;

    assign o_prod = (RCOL_W+CW)'(i_mul_a) * (RCOL_W+CW)'(i_mul_b);

    // w[more] > 1.0 so the result never wraps and fits back in SW bits
    assign sum      = {1'b0, i_wm} + {1'b0, i_wl} - (SW+1)'(ONE_Q24);
    assign o_res    = i_pair ? sum[SW-1:0] : i_pass;
    assign o_gt_one = (o_res > SW'(ONE_Q24));

endmodule

`default_nettype wire

// ===== bench/alias_table_sampler_checker.sv =====
`default_nettype none

// Watches both channels, predicts the result word of every accepted sample word and
// every accepted load word marked last, and compares field by field in order.
module alias_table_sampler_checker import ats_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // weight, rand_column, rand_coin
    input  wire logic [0:0]           i_s_tuser,  // op
    input  wire logic                 i_s_tlast,  // last
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,  // sample_index, error, overflow
    input  wire logic [0:0]           i_m_tuser,  // kind
    output int                        o_fail_count,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ONE = 64'(ONE_Q24);

    typedef struct packed {
        logic                 kind;
        logic [IDX_OUT_W-1:0] index;
        logic                 err;
        logic                 ovf;
    } t_outcome;

    t_outcome             due_q[$];
    longint unsigned      wt       [CAPACITY];
    logic [PROB_W-1:0]    prob_q   [CAPACITY];
    logic [IDX_OUT_W-1:0] alias_ix [CAPACITY];
    int                   sm_stack [CAPACITY];
    int                   lg_stack [CAPACITY];
    int                   fill;
    bit                   have_table;
    bit                   dropped;
    int                   fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        fail_count++;
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    // Vose pairing on weights scaled by the count, so 1.0 is the mean when the weights sum to 1.0.
    function automatic void build_alias_table();
        int n;
        int ns;
        int nl;
        int less;
        int more;
        int k;
        n  = fill;
        ns = 0;
        nl = 0;
        for (int i = 0; i < n; i++) begin
            wt[i] = wt[i] * longint'(n);
            if (wt[i] > ONE) begin
                lg_stack[nl] = i;
                nl++;
            end else begin
                sm_stack[ns] = i;
                ns++;
            end
        end
        while (ns > 0 && nl > 0) begin
            ns--;
            less = sm_stack[ns];
            nl--;
            more = lg_stack[nl];
            prob_q[less]   = wt[less][PROB_W-1:0];
            alias_ix[less] = IDX_OUT_W'(more);
            wt[more]       = wt[more] + wt[less] - ONE;
            if (wt[more] > ONE) begin
                lg_stack[nl] = more;
                nl++;
            end else begin
                sm_stack[ns] = more;
                ns++;
            end
        end
        while (ns > 0) begin
            ns--;
            k = sm_stack[ns];
            prob_q[k]   = ONE_Q24;
            alias_ix[k] = IDX_OUT_W'(k);
        end
        while (nl > 0) begin
            nl--;
            k = lg_stack[nl];
            prob_q[k]   = ONE_Q24;
            alias_ix[k] = IDX_OUT_W'(k);
        end
    endfunction

    task automatic take_word(logic op, logic [WEIGHT_W-1:0] w, logic last,
                             logic [RCOL_W-1:0] rc, logic [RCOIN_W-1:0] coin);
        t_outcome        res;
        longint unsigned col;
        res = '0;
        if (op == OP_LOAD) begin
            // a load after a finished build starts a fresh table
            if (have_table) begin
                have_table = 1'b0;
                fill       = 0;
                dropped    = 1'b0;
            end
            if (fill < CAPACITY) begin
                wt[fill] = longint'(w);
                fill++;
            end else begin
                dropped = 1'b1;
            end
            if (!last)
                return;
            res.kind = KIND_BUILD;
            res.ovf  = dropped;
            if (fill == 0) begin
                res.err    = 1'b1;
                have_table = 1'b0;
            end else begin
                build_alias_table();
                have_table = 1'b1;
            end
            dropped = 1'b0;
        end else begin
            res.kind = KIND_SAMPLE;
            if (!have_table || fill == 0) begin
                res.err = 1'b1;
            end else begin
                col = (64'(fill) * 64'(rc)) >> 32;
                if (col >= 64'(fill))
                    col = 64'(fill - 1);
                res.index = (64'(coin) < 64'(prob_q[col])) ? IDX_OUT_W'(col) : alias_ix[col];
            end
        end
        due_q = {due_q, res};
    endtask

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            due_q.delete();
            fill       = 0;
            have_table = 1'b0;
            dropped    = 1'b0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser[0], i_m_tdata[IDX_OUT_W-1:0], i_m_tdata[10], i_m_tdata[11]};
                if (due_q.size() == 0) begin
                    flag_mismatch("result word with nothing due", longint'(got), 0);
                end else begin
                    want = due_q.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch("kind", got.kind, want.kind);
                    if (got.index !== want.index)
                        flag_mismatch("sample_index", got.index, want.index);
                    if (got.err !== want.err)
                        flag_mismatch("error", got.err, want.err);
                    if (got.ovf !== want.ovf)
                        flag_mismatch("overflow", got.ovf, want.ovf);
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_word(i_s_tuser[0], i_s_tdata[WEIGHT_W-1:0], i_s_tlast,
                          i_s_tdata[WEIGHT_W +: RCOL_W],
                          i_s_tdata[WEIGHT_W+RCOL_W +: RCOIN_W]);
        end
        o_outstanding <= due_q.size();
    end

endmodule

`default_nettype wire

// ===== bench/tb_alias_table_sampler.sv =====
`default_nettype none

// Stimulus and verdict for the alias-table sampler. The checker beside the
// block does all prediction; this module only drives words, paces the receiver and waits.
module tb_alias_table_sampler import ats_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 1024;
    localparam int RANDOM_WORDS = 1350;    // includes the over-capacity table
    localparam int BULK_AT      = 200;     // random words before the over-capacity table
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int TAIL_CYCLES  = 100;     // quiet time after the last result
    localparam int WATCHDOG_NS  = 18_000_000;
    localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(ONE_Q24);

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // weight[24:0], rand_column[56:25], rand_coin[80:57]
    logic [0:0]           s_axis_tuser;   // op
    logic                 s_axis_tlast;   // last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // sample_index[9:0], error[10], overflow[11]
    logic [0:0]           m_axis_tuser;   // kind

    int fail_count;
    int outstanding;

    // Shared between the sender and the receiver process
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off
    bit calm     = 1'b0;   // no gaps and no stalls while set
    int sent_words = 0;

    alias_table_sampler #(
        .MAX_ENTRIES (ENTRIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    alias_table_sampler_checker #(
        .CAPACITY (ENTRIES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Gap before a word: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word and hold it until the block takes it. Called at a rising
    // edge, returns at the edge of the hand-off, so each signal gets one
    // nonblocking update per edge.
    task automatic offer_word(logic op, logic [WEIGHT_W-1:0] w, logic last,
                              logic [RCOL_W-1:0] rc, logic [RCOIN_W-1:0] coin);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[WEIGHT_W-1:0]               = w;
        word[WEIGHT_W +: RCOL_W]         = rc;
        word[WEIGHT_W+RCOL_W +: RCOIN_W] = coin;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sent_words++;
    endtask

    // Load word; the random-number fields are don't-care so they get noise.
    task automatic load_weight(logic [WEIGHT_W-1:0] w, logic last);
        offer_word(OP_LOAD, w, last, $urandom, RCOIN_W'($urandom));
    endtask

    // Sample word; weight and last are ignored so they get noise too.
    task automatic draw(logic [RCOL_W-1:0] rc, logic [RCOIN_W-1:0] coin);
        offer_word(OP_SAMPLE, WEIGHT_W'($urandom_range(0, 1 << 24)), 1'($urandom), rc, coin);
    endtask

    task automatic draw_burst(int k);
        for (int i = 0; i < k; i++)
            draw($urandom, RCOIN_W'($urandom));
    endtask

    // Drop tvalid and wait until every predicted result word has come back.
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    // Table of n weights that sum to exactly 1.0; the final one carries the
    // remainder. Optionally a sample slips in mid-load (no table then).
    task automatic load_normalised_table(int n, bit mid_draw);
        int rest;
        int w;
        rest = int'(ONE_Q24);
        for (int i = 0; i < n - 1; i++) begin
            w = $urandom_range(0, (2 * rest) / (n - i));
            if (w > rest)
                w = rest;
            rest -= w;
            load_weight(WEIGHT_W'(w), 1'b0);
            if (mid_draw && i == 0)
                draw($urandom, RCOIN_W'($urandom));
        end
        load_weight(WEIGHT_W'(rest), 1'b1);
    endtask

    // Weights anywhere in 0..1.0 with no regard for their sum.
    task automatic load_noise_table(int n);
        for (int i = 0; i < n; i++)
            load_weight(WEIGHT_W'($urandom_range(0, 1 << 24)), i == n - 1);
    endtask

    // Receiver: random ready/stall runs, a calm mode and one long hold-off.
    initial begin
        int r;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end else if (r < 93) begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("alias_table_sampler verification failed");
        $finish;
    end

    // Sender and verdict
    initial begin
        int  base_words;
        int  pick;
        int  n;
        int  extra;
        bit  held;
        bit  bulk_done;

        held       = 1'b0;
        bulk_done  = 1'b0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // sample with no table at all: error
        draw('1, '1);
        // single full-scale weight: one-entry table, every draw lands on 0
        load_weight(W_ONE, 1'b1);
        draw('0, '0);
        draw('1, '1);
        // zero weight plus two halves, sum is exactly 1.0
        load_weight('0, 1'b0);
        load_weight(WEIGHT_W'(1 << 23), 1'b0);
        load_weight(WEIGHT_W'(1 << 23), 1'b1);
        draw('0, '0);
        draw('1, '1);
        draw(32'h5555_5555, 24'h80_0000);
        draw(32'hAAAA_AAAA, 24'h7F_FFFF);
        // load after a finished build drops the table; a sample mid-load errors
        load_weight(WEIGHT_W'(1 << 22), 1'b0);
        draw(32'h8000_0000, 24'h00_0001);
        load_weight(WEIGHT_W'(3 << 22), 1'b1);
        draw(32'hC000_0000, 24'h40_0000);
        draw(32'h3FFF_FFFF, 24'hBF_FFFF);
        // weights summing to 2.0
        load_weight(W_ONE, 1'b0);
        load_weight(W_ONE, 1'b1);
        draw(32'h8000_0000, '1);
        // weights summing to zero: every entry small
        load_weight('0, 1'b0);
        load_weight('0, 1'b1);
        draw('1, '0);
        draw('0, '1);
        drain_pause();

        // ---- random ----
        base_words = sent_words;
        while (sent_words - base_words < RANDOM_WORDS) begin
            calm = ($urandom_range(0, 5) == 0);

            // One table past capacity: the surplus loads are dropped and the
            // build reports overflow. Then a burst of 60 random draws on the full table.
            if (!bulk_done && sent_words - base_words >= BULK_AT) begin
                extra = $urandom_range(1, 5);
                load_noise_table(ENTRIES + extra);
                bulk_done = 1'b1;
                draw_burst(60);
            end

            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                load_normalised_table(n, n > 1 && $urandom_range(0, 9) == 0);
                draw_burst($urandom_range(1, 20));
            end else if (pick < 85) begin
                load_noise_table($urandom_range(1, 12));
                draw_burst($urandom_range(1, 10));
            end else begin
                draw_burst($urandom_range(1, 15));
            end

            // One long hold-off on the result side while words keep coming,
            // so the block backs up and stalls its input.
            if (!held && sent_words - base_words > 300) begin
                held     = 1'b1;
                calm     = 1'b0;
                hold_req = 1'b1;
                draw_burst(30);
            end

            if ($urandom_range(0, 9) == 0)
                drain_pause();
        end

        // ---- wind-down ----
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("alias_table_sampler verification clean");
        end else begin
            $display("alias_table_sampler verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/ats_pkg.sv
rtl/ats_stack.sv
rtl/ats_alu.sv
rtl/alias_table_sampler.sv
bench/alias_table_sampler_checker.sv
bench/tb_alias_table_sampler.sv
